// File: sv/ezr_pkg.sv
// ---------------------------------------------------------------------------
// ezr_pkg: shared constants for the Euler XYZ rotation matrix block
// Fixed-point widths, angle constants and the CORDIC arctangent table.
// ---------------------------------------------------------------------------
package ezr_pkg;

   localparam int SINCOS_ITERATIONS_DEF = 16;
   localparam int MAX_ITERATIONS        = 24;

   // Field widths
   localparam int ANGLE_W = 16;
   localparam int ELEM_W  = 16;

   // Internal widths: Q.30 angle after wrap and CORDIC x/y, Q.20 sin/cos
   localparam int ZRAW_W = 36;
   localparam int Z_W    = 33;
   localparam int XY_W   = 33;
   localparam int SC_W   = 23;
   localparam int PROD_W = 2 * SC_W;
   localparam int TRI_W  = PROD_W - 20;
   localparam int SUM_W  = TRI_W + SC_W + 1;

   // Angle constants, Q.30
   localparam logic signed [ZRAW_W-1:0] PI_Q30      = 36'sd3373259426;
   localparam logic signed [ZRAW_W-1:0] TWO_PI_Q30  = 36'sd6746518852;
   localparam logic signed [Z_W-1:0]    HALF_PI_Q30 = 33'sd1686629713;
   localparam logic signed [XY_W-1:0]   K_Q30       = 33'sd652032874;

   localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

   // atan(2^-i) in Q.30
   localparam logic signed [Z_W-1:0] ATAN_TAB [MAX_ITERATIONS] = '{
      33'sd843314857, 33'sd497837829, 33'sd263043837, 33'sd133525159,
      33'sd67021687,  33'sd33543516,  33'sd16775851,  33'sd8388437,
      33'sd4194283,   33'sd2097149,   33'sd1048576,   33'sd524288,
      33'sd262144,    33'sd131072,    33'sd65536,     33'sd32768,
      33'sd16384,     33'sd8192,      33'sd4096,      33'sd2048,
      33'sd1024,      33'sd512,       33'sd256,       33'sd128
   };

endpackage

// File: sv/ezr_cordic.sv
// ---------------------------------------------------------------------------
// ezr_cordic: pipelined sine/cosine unit
// Wraps a Q3.12 angle into [-pi, pi], folds it into [-pi/2, pi/2], runs one
// rotation-mode CORDIC step per stage and rounds both results to Q.20.
// One angle per cycle; the wrap, the fold, each iteration and the rounded results are registered.
// ---------------------------------------------------------------------------
module ezr_cordic #(
   parameter int SINCOS_ITERATIONS = ezr_pkg::SINCOS_ITERATIONS_DEF
) (
   input  logic                                   clock,
   input  logic signed [ezr_pkg::ANGLE_W-1:0]     angle,
   output logic signed [ezr_pkg::SC_W-1:0]        sin_q20,
   output logic signed [ezr_pkg::SC_W-1:0]        cos_q20
);

   localparam int N = SINCOS_ITERATIONS;

   logic signed [ezr_pkg::ZRAW_W-1:0] zraw;
   logic signed [ezr_pkg::ZRAW_W-1:0] zwrap_in;
   logic signed [ezr_pkg::Z_W-1:0]    zwrap_ff;
   logic signed [ezr_pkg::Z_W-1:0]    zfold_in;
   logic                              neg_in;

   logic signed [ezr_pkg::XY_W-1:0] x_ff [0:N];
   logic signed [ezr_pkg::XY_W-1:0] y_ff [0:N];
   logic signed [ezr_pkg::Z_W-1:0]  z_ff [0:N];
   logic                            neg_ff [0:N];

   logic signed [ezr_pkg::XY_W-1:0] xf, yf;
   logic signed [ezr_pkg::XY_W-1:0] cos_rnd, sin_rnd;
   logic signed [ezr_pkg::SC_W-1:0] sin_ff, cos_ff;

   // Stage A: scale to Q.30 and wrap by two pi
   always_comb begin
      zraw = ezr_pkg::ZRAW_W'(angle) <<< 18;
      if (zraw > ezr_pkg::PI_Q30) begin
         zwrap_in = zraw - ezr_pkg::TWO_PI_Q30;
      end else if (zraw < -ezr_pkg::PI_Q30) begin
         zwrap_in = zraw + ezr_pkg::TWO_PI_Q30;
      end else begin
         zwrap_in = zraw;
      end
   end

   always_ff @(posedge clock) begin
      zwrap_ff <= zwrap_in[ezr_pkg::Z_W-1:0];
   end

   // Stage B: fold into the right half plane
   always_comb begin
      if (zwrap_ff > ezr_pkg::HALF_PI_Q30) begin
         zfold_in = zwrap_ff - ezr_pkg::PI_Q30[ezr_pkg::Z_W-1:0];
         neg_in   = 1'b1;
      end else if (zwrap_ff < -ezr_pkg::HALF_PI_Q30) begin
         zfold_in = zwrap_ff + ezr_pkg::PI_Q30[ezr_pkg::Z_W-1:0];
         neg_in   = 1'b1;
      end else begin
         zfold_in = zwrap_ff;
         neg_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      x_ff[0]   <= ezr_pkg::K_Q30;
      y_ff[0]   <= '0;
      z_ff[0]   <= zfold_in;
      neg_ff[0] <= neg_in;
   end

   // CORDIC iterations, one per stage
   for (genvar i = 0; i < N; i++) begin : g_iter
      logic signed [ezr_pkg::XY_W-1:0] dx, dy;
      assign dx = y_ff[i] >>> i;
      assign dy = x_ff[i] >>> i;
      always_ff @(posedge clock) begin
         neg_ff[i+1] <= neg_ff[i];
         if (z_ff[i] >= 0) begin
            x_ff[i+1] <= x_ff[i] - dx;
            y_ff[i+1] <= y_ff[i] + dy;
            z_ff[i+1] <= z_ff[i] - ezr_pkg::ATAN_TAB[i];
         end else begin
            x_ff[i+1] <= x_ff[i] + dx;
            y_ff[i+1] <= y_ff[i] - dy;
            z_ff[i+1] <= z_ff[i] + ezr_pkg::ATAN_TAB[i];
         end
      end
   end

   // Final stage: undo the fold and round to Q.20
   always_comb begin
      xf      = neg_ff[N] ? -x_ff[N] : x_ff[N];
      yf      = neg_ff[N] ? -y_ff[N] : y_ff[N];
      cos_rnd = (xf + ezr_pkg::XY_W'(512)) >>> 10;
      sin_rnd = (yf + ezr_pkg::XY_W'(512)) >>> 10;
   end

   always_ff @(posedge clock) begin
      cos_ff <= cos_rnd[ezr_pkg::SC_W-1:0];
      sin_ff <= sin_rnd[ezr_pkg::SC_W-1:0];
   end

   assign sin_q20 = sin_ff;
   assign cos_q20 = cos_ff;

endmodule

// File: sv/euler_xyz_rotation_matrix.sv
// ---------------------------------------------------------------------------
// euler_xyz_rotation_matrix: XYZ Euler angles to 3x3 rotation matrix
// Three angles in signed Q3.12 radians in, nine Q1.14 entries out.
// ---------------------------------------------------------------------------
// Usage:
//  - Drive req_angle_x/y/z and pulse start; the transaction is taken at any
//    edge with start high and busy low. busy is held low: the datapath is
//    fully pipelined and takes one transaction every cycle.
//  - Three CORDIC pipelines (one per angle) form sin/cos in Q.20, then four
//    stages form the triple-product pre-terms, the products, the sums and the
//    rounded, saturated Q1.14 entries.
//  - The delay from start to rsp_valid is set by the CORDIC depth (one step
//    per stage) plus the product stages.
//  - Throughput is one transaction per cycle.
//  - rsp_valid is high for exactly one cycle per transaction with all nine
//    entries alongside; the receiver takes it that cycle and cannot stall.
//  - Reset clears the valid pipeline; transactions in flight are dropped.
// ---------------------------------------------------------------------------
module euler_xyz_rotation_matrix #(
   parameter int SINCOS_ITERATIONS = ezr_pkg::SINCOS_ITERATIONS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [ezr_pkg::ANGLE_W-1:0]  req_angle_x,
   input  logic signed [ezr_pkg::ANGLE_W-1:0]  req_angle_y,
   input  logic signed [ezr_pkg::ANGLE_W-1:0]  req_angle_z,
   output logic                                rsp_valid,
   output logic signed [ezr_pkg::ELEM_W-1:0]   rsp_elem_r0_c0,
   output logic signed [ezr_pkg::ELEM_W-1:0]   rsp_elem_r1_c0,
   output logic signed [ezr_pkg::ELEM_W-1:0]   rsp_elem_r2_c0,
   output logic signed [ezr_pkg::ELEM_W-1:0]   rsp_elem_r0_c1,
   output logic signed [ezr_pkg::ELEM_W-1:0]   rsp_elem_r1_c1,
   output logic signed [ezr_pkg::ELEM_W-1:0]   rsp_elem_r2_c1,
   output logic signed [ezr_pkg::ELEM_W-1:0]   rsp_elem_r0_c2,
   output logic signed [ezr_pkg::ELEM_W-1:0]   rsp_elem_r1_c2,
   output logic signed [ezr_pkg::ELEM_W-1:0]   rsp_elem_r2_c2
);

   localparam int SC_W   = ezr_pkg::SC_W;
   localparam int PROD_W = ezr_pkg::PROD_W;
   localparam int TRI_W  = ezr_pkg::TRI_W;
   localparam int SUM_W  = ezr_pkg::SUM_W;
   localparam int LAT    = SINCOS_ITERATIONS + 7;

   logic signed [SC_W-1:0] sx, cx, sy, cy, sz, cz;

   // Valid bits travel alongside the datapath
   logic [LAT-1:0] vld_ff;
   logic [LAT-1:0] vld_in;

   assign busy   = 1'b0;
   assign vld_in = {vld_ff[LAT-2:0], start};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Sine/cosine pipelines
   ezr_cordic #(.SINCOS_ITERATIONS(SINCOS_ITERATIONS)) u_cordic_x (
      .clock(clock), .angle(req_angle_x), .sin_q20(sx), .cos_q20(cx));
   ezr_cordic #(.SINCOS_ITERATIONS(SINCOS_ITERATIONS)) u_cordic_y (
      .clock(clock), .angle(req_angle_y), .sin_q20(sy), .cos_q20(cy));
   ezr_cordic #(.SINCOS_ITERATIONS(SINCOS_ITERATIONS)) u_cordic_z (
      .clock(clock), .angle(req_angle_z), .sin_q20(sz), .cos_q20(cz));

   // Stage P1: pre-products for the triple terms
   logic signed [PROD_W-1:0] sxsy_ff, cxsy_ff;
   logic signed [SC_W-1:0]   sx1_ff, cx1_ff, sy1_ff, cy1_ff, sz1_ff, cz1_ff;

   always_ff @(posedge clock) begin
      sxsy_ff <= sx * sy;
      cxsy_ff <= cx * sy;
      sx1_ff  <= sx;
      cx1_ff  <= cx;
      sy1_ff  <= sy;
      cy1_ff  <= cy;
      sz1_ff  <= sz;
      cz1_ff  <= cz;
   end

   // Stage P2: round pre-products to Q.20, form all Q.40 products
   logic signed [PROD_W-1:0] sxsy_r, cxsy_r;
   logic signed [TRI_W-1:0]  sxsy20, cxsy20;

   always_comb begin
      sxsy_r = (sxsy_ff + PROD_W'(1 << 19)) >>> 20;
      cxsy_r = (cxsy_ff + PROD_W'(1 << 19)) >>> 20;
      sxsy20 = sxsy_r[TRI_W-1:0];
      cxsy20 = cxsy_r[TRI_W-1:0];
   end

   logic signed [SUM_W-1:0] cycz_ff, cysz_ff, sy40_ff, cxsz_ff, sxsycz_ff, cxcz_ff;
   logic signed [SUM_W-1:0] sxsysz_ff, sxcy_ff, sxsz_ff, cxsycz_ff, sxcz_ff, cxsysz_ff;
   logic signed [SUM_W-1:0] cxcy_ff;

   always_ff @(posedge clock) begin
      cycz_ff   <= SUM_W'(cy1_ff * cz1_ff);
      cysz_ff   <= SUM_W'(cy1_ff * sz1_ff);
      sy40_ff   <= SUM_W'(sy1_ff) <<< 20;
      cxsz_ff   <= SUM_W'(cx1_ff * sz1_ff);
      sxsycz_ff <= SUM_W'(sxsy20 * cz1_ff);
      cxcz_ff   <= SUM_W'(cx1_ff * cz1_ff);
      sxsysz_ff <= SUM_W'(sxsy20 * sz1_ff);
      sxcy_ff   <= SUM_W'(sx1_ff * cy1_ff);
      sxsz_ff   <= SUM_W'(sx1_ff * sz1_ff);
      cxsycz_ff <= SUM_W'(cxsy20 * cz1_ff);
      sxcz_ff   <= SUM_W'(sx1_ff * cz1_ff);
      cxsysz_ff <= SUM_W'(cxsy20 * sz1_ff);
      cxcy_ff   <= SUM_W'(cx1_ff * cy1_ff);
   end

   // Stage P3: sums per entry
   logic signed [SUM_W-1:0] sum_ff [9];

   always_ff @(posedge clock) begin
      sum_ff[0] <= cycz_ff;
      sum_ff[1] <= -cysz_ff;
      sum_ff[2] <= sy40_ff;
      sum_ff[3] <= cxsz_ff + sxsycz_ff;
      sum_ff[4] <= cxcz_ff - sxsysz_ff;
      sum_ff[5] <= -sxcy_ff;
      sum_ff[6] <= sxsz_ff - cxsycz_ff;
      sum_ff[7] <= sxcz_ff + cxsysz_ff;
      sum_ff[8] <= cxcy_ff;
   end

   // Stage P4: round to Q1.14 and saturate
   logic signed [ezr_pkg::ELEM_W-1:0] elem_ff [9];
   logic signed [ezr_pkg::ELEM_W-1:0] elem_in [9];

   for (genvar e = 0; e < 9; e++) begin : g_fin
      logic signed [SUM_W-1:0] rnd;
      always_comb begin
         rnd = (sum_ff[e] + SUM_W'(1 << 25)) >>> 26;
         if (rnd > SUM_W'(ezr_pkg::ONE_Q14)) begin
            elem_in[e] = ezr_pkg::ONE_Q14;
         end else if (rnd < -SUM_W'(ezr_pkg::ONE_Q14)) begin
            elem_in[e] = -ezr_pkg::ONE_Q14;
         end else begin
            elem_in[e] = rnd[ezr_pkg::ELEM_W-1:0];
         end
      end
      always_ff @(posedge clock) begin
         elem_ff[e] <= elem_in[e];
      end
   end

   assign rsp_valid      = vld_ff[LAT-1];
   assign rsp_elem_r0_c0 = elem_ff[0];
   assign rsp_elem_r1_c0 = elem_ff[1];
   assign rsp_elem_r2_c0 = elem_ff[2];
   assign rsp_elem_r0_c1 = elem_ff[3];
   assign rsp_elem_r1_c1 = elem_ff[4];
   assign rsp_elem_r2_c1 = elem_ff[5];
   assign rsp_elem_r0_c2 = elem_ff[6];
   assign rsp_elem_r1_c2 = elem_ff[7];
   assign rsp_elem_r2_c2 = elem_ff[8];

endmodule

// File: test/euler_xyz_rotation_matrix_check.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// euler_xyz_rotation_matrix_check: matrix predictor and response checker
// Watches the angle and matrix channels, computes the expected nine entries
// of every accepted angle triple and compares them in order with the block's
// responses.
// ---------------------------------------------------------------------------
module euler_xyz_rotation_matrix_check #(
   parameter int SINCOS_ITERATIONS = ezr_pkg::SINCOS_ITERATIONS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic                               busy,
   input  logic signed [ezr_pkg::ANGLE_W-1:0] req_angle_x,
   input  logic signed [ezr_pkg::ANGLE_W-1:0] req_angle_y,
   input  logic signed [ezr_pkg::ANGLE_W-1:0] req_angle_z,
   input  logic                               rsp_valid,
   input  logic signed [ezr_pkg::ELEM_W-1:0]  rsp_elem_r0_c0,
   input  logic signed [ezr_pkg::ELEM_W-1:0]  rsp_elem_r1_c0,
   input  logic signed [ezr_pkg::ELEM_W-1:0]  rsp_elem_r2_c0,
   input  logic signed [ezr_pkg::ELEM_W-1:0]  rsp_elem_r0_c1,
   input  logic signed [ezr_pkg::ELEM_W-1:0]  rsp_elem_r1_c1,
   input  logic signed [ezr_pkg::ELEM_W-1:0]  rsp_elem_r2_c1,
   input  logic signed [ezr_pkg::ELEM_W-1:0]  rsp_elem_r0_c2,
   input  logic signed [ezr_pkg::ELEM_W-1:0]  rsp_elem_r1_c2,
   input  logic signed [ezr_pkg::ELEM_W-1:0]  rsp_elem_r2_c2,
   output int                                 error_count,
   output int                                 pending_count
);

   typedef logic signed [ezr_pkg::ELEM_W-1:0] elem_type;
   typedef struct {
      elem_type e [9];
   } matrix_type;

   localparam longint PI_FIX   = 64'sd3373259426;
   localparam longint GAIN_FIX = 64'sd652032874;

   longint     arctan_q30 [SINCOS_ITERATIONS];
   matrix_type matrix_queue [$];

   // arctangent table from the power series of atan(2^-i)
   initial begin
      longint sum;
      int     k;
      int     e;
      for (int i = 0; i < SINCOS_ITERATIONS; i++) begin
         if (i == 0) begin
            arctan_q30[i] = 64'sd843314857;
         end else begin
            sum = 0;
            k   = 0;
            e   = 62 - i;
            while (e >= 0) begin
               if (k % 2 == 1) sum -= (64'sd1 <<< e) / (2 * k + 1);
               else sum += (64'sd1 <<< e) / (2 * k + 1);
               k++;
               e = 62 - i * (2 * k + 1);
            end
            arctan_q30[i] = (sum + (64'sd1 <<< 31)) >>> 32;
         end
      end
   end

   // sine and cosine of a Q3.12 angle, Q.20
   task automatic angle_sincos(input logic signed [15:0] ang, output longint s,
                               output longint c);
      longint z;
      longint x;
      longint y;
      longint dx;
      longint dy;
      bit     flip;
      z    = longint'(ang) * 262144;
      x    = GAIN_FIX;
      y    = 0;
      flip = 0;
      if (z > PI_FIX) z -= 2 * PI_FIX;
      else if (z < -PI_FIX) z += 2 * PI_FIX;
      if (z > PI_FIX / 2) begin
         z -= PI_FIX;
         flip = 1;
      end else if (z < -(PI_FIX / 2)) begin
         z += PI_FIX;
         flip = 1;
      end
      for (int i = 0; i < SINCOS_ITERATIONS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx;
            y += dy;
            z -= arctan_q30[i];
         end else begin
            x += dx;
            y -= dy;
            z += arctan_q30[i];
         end
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      c = (x + 512) >>> 10;
      s = (y + 512) >>> 10;
   endtask

   // Q.40 to saturated Q1.14
   function automatic elem_type to_entry(longint v);
      longint r;
      r = (v + (64'sd1 <<< 25)) >>> 26;
      if (r > 16384) r = 16384;
      if (r < -16384) r = -16384;
      return elem_type'(r);
   endfunction

   task automatic predict_matrix(input logic signed [15:0] ax, ay, az,
                                 output matrix_type m);
      longint sx, cx, sy, cy, sz, cz, sxsy, cxsy;
      angle_sincos(ax, sx, cx);
      angle_sincos(ay, sy, cy);
      angle_sincos(az, sz, cz);
      sxsy   = (sx * sy + (64'sd1 <<< 19)) >>> 20;
      cxsy   = (cx * sy + (64'sd1 <<< 19)) >>> 20;
      m.e[0] = to_entry(cy * cz);
      m.e[1] = to_entry(-(cy * sz));
      m.e[2] = to_entry(sy * (64'sd1 <<< 20));
      m.e[3] = to_entry(cx * sz + sxsy * cz);
      m.e[4] = to_entry(cx * cz - sxsy * sz);
      m.e[5] = to_entry(-(sx * cy));
      m.e[6] = to_entry(sx * sz - cxsy * cz);
      m.e[7] = to_entry(sx * cz + cxsy * sz);
      m.e[8] = to_entry(cx * cy);
   endtask

   // predict on each accepted transaction, compare on each response
   initial begin
      error_count   = 0;
      pending_count = 0;
   end

   always @(posedge clock) begin
      matrix_type want;
      elem_type   got [9];
      bit         bad;
      if (!reset) begin
         if (start && !busy) begin
            predict_matrix(req_angle_x, req_angle_y, req_angle_z, want);
            matrix_queue.push_back(want);
         end
         if (rsp_valid) begin
            got = '{rsp_elem_r0_c0, rsp_elem_r1_c0, rsp_elem_r2_c0,
                    rsp_elem_r0_c1, rsp_elem_r1_c1, rsp_elem_r2_c1,
                    rsp_elem_r0_c2, rsp_elem_r1_c2, rsp_elem_r2_c2};
            if (matrix_queue.size() == 0) begin
               if (error_count < 10)
                  $display("unexpected response at %0t", $realtime);
               error_count++;
            end else begin
               want = matrix_queue.pop_front();
               bad  = 0;
               for (int i = 0; i < 9; i++)
                  if (got[i] !== want.e[i]) bad = 1;
               if (bad) begin
                  if (error_count < 10)
                     for (int i = 0; i < 9; i++)
                        if (got[i] !== want.e[i])
                           $display("entry r%0d_c%0d: expected %0d got %0d",
                                    i % 3, i / 3, want.e[i], got[i]);
                  error_count++;
               end
            end
         end
      end
      pending_count = matrix_queue.size();
   end

endmodule

// File: test/euler_xyz_rotation_matrix_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// euler_xyz_rotation_matrix_test: testbench top for the rotation matrix block
// Drives directed and random angle triples with varying sender idle rates;
// a checker beside the block predicts and compares every matrix.
// ---------------------------------------------------------------------------
module euler_xyz_rotation_matrix_test;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int PI_Q12         = 12868;
   localparam int HALF_PI_Q12    = 6434;

   logic              clock = 0;
   logic              reset = 1;
   logic              start = 0;
   logic              busy;
   logic signed [15:0] req_angle_x = 0;
   logic signed [15:0] req_angle_y = 0;
   logic signed [15:0] req_angle_z = 0;
   logic              rsp_valid;
   logic signed [15:0] r00, r10, r20, r01, r11, r21, r02, r12, r22;
   int                error_count;
   int                pending_count;
   int                idle_cycles = 0;
   int                idle_pct    = 0;

   always #1 clock = ~clock;

   euler_xyz_rotation_matrix dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_angle_x(req_angle_x), .req_angle_y(req_angle_y),
      .req_angle_z(req_angle_z), .rsp_valid(rsp_valid),
      .rsp_elem_r0_c0(r00), .rsp_elem_r1_c0(r10), .rsp_elem_r2_c0(r20),
      .rsp_elem_r0_c1(r01), .rsp_elem_r1_c1(r11), .rsp_elem_r2_c1(r21),
      .rsp_elem_r0_c2(r02), .rsp_elem_r1_c2(r12), .rsp_elem_r2_c2(r22)
   );

   euler_xyz_rotation_matrix_check check (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_angle_x(req_angle_x), .req_angle_y(req_angle_y),
      .req_angle_z(req_angle_z), .rsp_valid(rsp_valid),
      .rsp_elem_r0_c0(r00), .rsp_elem_r1_c0(r10), .rsp_elem_r2_c0(r20),
      .rsp_elem_r0_c1(r01), .rsp_elem_r1_c1(r11), .rsp_elem_r2_c1(r21),
      .rsp_elem_r0_c2(r02), .rsp_elem_r1_c2(r12), .rsp_elem_r2_c2(r22),
      .error_count(error_count), .pending_count(pending_count)
   );

   // watchdog: cycles without any transaction
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // one transaction, then idle cycles drawn one at a time
   task automatic send_angles(input logic signed [15:0] ax, ay, az);
      start       <= 1;
      req_angle_x <= ax;
      req_angle_y <= ay;
      req_angle_z <= az;
      do @(posedge clock); while (busy);
      while ($urandom_range(99) < idle_pct) begin
         start <= 0;
         @(posedge clock);
      end
   endtask

   // angle picked near a fold or wrap boundary, or anywhere
   function automatic logic signed [15:0] pick_angle();
      int base;
      case ($urandom_range(3))
         0: base = PI_Q12;
         1: base = HALF_PI_Q12;
         2: base = 2 * PI_Q12;
         default: return 16'($urandom);
      endcase
      if ($urandom_range(1)) base = -base;
      return 16'(base + $urandom_range(8) - 4);
   endfunction

   initial begin
      logic signed [15:0] edge_vals [10];
      edge_vals = '{16'sh8000, 16'sh7fff, 16'sd0, 16'sd12868, -16'sd12868,
                    16'sd6434, -16'sd6434, 16'sd6435, -16'sd12869, 16'sd25736};
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes and fold / wrap boundaries
      for (int i = 0; i < 10; i++)
         send_angles(edge_vals[i], edge_vals[(i + 3) % 10], edge_vals[(i + 7) % 10]);
      send_angles(16'sh7fff, 16'sh7fff, 16'sh7fff);
      send_angles(16'sh8000, 16'sh8000, 16'sh8000);
      send_angles(16'sd6434, 16'sd6434, 16'sd6434);
      send_angles(-16'sd6435, 16'sd12869, -16'sd6434);
      send_angles(16'sh5555, 16'shaaaa, 16'sh0001);

      // random phases with different sender idle rates
      foreach (edge_vals[p]) begin
         if (p < 4) begin
            idle_pct = (p == 1) ? 65 : (p == 3) ? 14 : 0;
            for (int n = 0; n < 490; n++) begin
               if ($urandom_range(1))
                  send_angles(16'($urandom), 16'($urandom), 16'($urandom));
               else
                  send_angles(pick_angle(), pick_angle(), pick_angle());
            end
         end
      end
      start <= 0;

      wait (pending_count == 0);
      repeat (40) @(posedge clock);
      if (error_count == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule
